@@ design/lpd_pkg.sv @@
// package for the length-prefixed deframer
// types, constants and register map for the deframer; no dependencies
package lpd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int HDR_IDX_W = $clog2(HEADER_BYTES);
    localparam int HDR_CNT_W = HDR_IDX_W + 1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [31:0] MAX_LEN_RESET = 32'd4194304;

    // register indexes, taken from paddr[2]
    localparam logic REG_MAX_LEN = 1'b0;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_DROP    = 2'd2
    } lpd_kind_t;

    typedef struct packed {
        lpd_kind_t   result_kind;
        logic [31:0] message_type;
        logic [31:0] message_length;
        logic [7:0]  payload_byte;
        logic [31:0] byte_index;
        logic        end_of_message;
    } lpd_result_t;

endpackage

@@ design/lpd_stream_if.sv @@
// valid/ready channel interfaces of the deframer: input byte stream and result stream
// depends on nothing
interface lpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface lpd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] message_type;
    logic [31:0] message_length;
    logic [7:0]  payload_byte;
    logic [31:0] byte_index;
    logic        end_of_message;

    modport source (
        output valid, output result_kind, output message_type, output message_length,
        output payload_byte, output byte_index, output end_of_message, input ready
    );
    modport sink (
        input valid, input result_kind, input message_type, input message_length,
        input payload_byte, input byte_index, input end_of_message, output ready
    );
endinterface

@@ design/lpd_cfg_regs.sv @@
// apb register block of the deframer: holds the payload length limit
// depends on lpd_pkg
module lpd_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lpd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lpd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [31:0]                    max_len
);

    logic [31:0] max_len_reg;
    logic [31:0] max_len_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        max_len_next = max_len_reg;
        if (wr_en && (paddr[2] == lpd_pkg::REG_MAX_LEN))
        begin
            max_len_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= lpd_pkg::MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            lpd_pkg::REG_MAX_LEN: prdata = max_len_reg;
            default:              prdata = '0;
        endcase
    end

    assign max_len = max_len_reg;

endmodule

@@ design/lpd_input_stage.sv @@
// input register of the deframer: takes one byte transfer per cycle unless the held byte is stalled
// depends on lpd_byte_if
module lpd_input_stage (
    input  logic         clk,
    input  logic         rst_n,
    lpd_byte_if.sink     stream,
    input  logic         advance,
    output logic         held_valid,
    output logic [7:0]   held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign stream.ready = !valid_reg || advance;
    assign take         = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= stream.in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

@@ design/lpd_core.sv @@
// deframing state: header collection, length check and payload counting
// depends on lpd_pkg
module lpd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          in_byte,
    input  logic [31:0]         max_len,
    output logic                res_valid,
    output lpd_pkg::lpd_result_t res
);

    logic [lpd_pkg::HDR_CNT_W-1:0] hdr_count_reg;
    logic [lpd_pkg::HDR_CNT_W-1:0] hdr_count_next;
    logic [31:0]                   type_reg;
    logic [31:0]                   type_next;
    logic [31:0]                   length_reg;
    logic [31:0]                   length_next;
    logic [31:0]                   pcount_reg;
    logic [31:0]                   pcount_next;
    logic [7:0]                    hdr_reg [0:lpd_pkg::HEADER_BYTES-2];

    logic        in_header;
    logic        hdr_last;
    logic [31:0] hdr_type;
    logic [31:0] hdr_len;
    logic [32:0] idx_inc;
    logic        last;

    assign in_header = hdr_count_reg < lpd_pkg::HDR_CNT_W'(lpd_pkg::HEADER_BYTES);
    assign hdr_last  = hdr_count_reg == lpd_pkg::HDR_CNT_W'(lpd_pkg::HEADER_BYTES - 1);
    assign hdr_type  = {hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign hdr_len   = {in_byte, hdr_reg[6], hdr_reg[5], hdr_reg[4]};
    // wide increment so an index of all ones still ends the message
    assign idx_inc   = {1'b0, pcount_reg} + 33'd1;
    assign last      = idx_inc >= {1'b0, length_reg};

    always_comb
    begin
        hdr_count_next = hdr_count_reg;
        type_next      = type_reg;
        length_next    = length_reg;
        pcount_next    = pcount_reg;
        res_valid      = 1'b0;
        res            = '{
            result_kind:    lpd_pkg::KIND_PAYLOAD,
            message_type:   type_reg,
            message_length: length_reg,
            payload_byte:   8'd0,
            byte_index:     32'd0,
            end_of_message: 1'b0
        };
        if (fire)
        begin
            if (in_header)
            begin
                if (!hdr_last)
                begin
                    hdr_count_next = hdr_count_reg + 1'b1;
                end
                else
                begin
                    type_next              = hdr_type;
                    length_next            = hdr_len;
                    res.message_type       = hdr_type;
                    res.message_length     = hdr_len;
                    if (hdr_len > max_len)
                    begin
                        // oversize header dropped, next byte starts a new header
                        res_valid       = 1'b1;
                        res.result_kind = lpd_pkg::KIND_DROP;
                        hdr_count_next  = '0;
                    end
                    else if (hdr_len == 32'd0)
                    begin
                        res_valid          = 1'b1;
                        res.result_kind    = lpd_pkg::KIND_EMPTY;
                        res.end_of_message = 1'b1;
                        hdr_count_next     = '0;
                        length_next        = 32'd0;
                        pcount_next        = 32'd0;
                    end
                    else
                    begin
                        hdr_count_next = hdr_count_reg + 1'b1;
                        pcount_next    = 32'd0;
                    end
                end
            end
            else
            begin
                res_valid          = 1'b1;
                res.payload_byte   = in_byte;
                res.byte_index     = pcount_reg;
                res.end_of_message = last;
                if (last)
                begin
                    hdr_count_next = '0;
                    length_next    = 32'd0;
                    pcount_next    = 32'd0;
                end
                else
                begin
                    pcount_next = idx_inc[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_count_reg <= '0;
            type_reg      <= '0;
            length_reg    <= '0;
            pcount_reg    <= '0;
        end
        else
        begin
            hdr_count_reg <= hdr_count_next;
            type_reg      <= type_next;
            length_reg    <= length_next;
            pcount_reg    <= pcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_header && !hdr_last)
        begin
            hdr_reg[hdr_count_reg[lpd_pkg::HDR_IDX_W-1:0]] <= in_byte;
        end
    end

endmodule

@@ design/lpd_output_stage.sv @@
// result register of the deframer: holds one result until its transfer completes
// depends on lpd_pkg and lpd_result_if
module lpd_output_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    lpd_result_if.source         result,
    input  logic                 load,
    input  lpd_pkg::lpd_result_t load_data,
    output logic                 can_take
);

    logic                 valid_reg;
    logic                 valid_next;
    lpd_pkg::lpd_result_t data_reg;

    assign can_take   = !valid_reg || result.ready;
    assign valid_next = can_take ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && load)
        begin
            data_reg <= load_data;
        end
    end

    assign result.valid          = valid_reg;
    assign result.result_kind    = data_reg.result_kind;
    assign result.message_type   = data_reg.message_type;
    assign result.message_length = data_reg.message_length;
    assign result.payload_byte   = data_reg.payload_byte;
    assign result.byte_index     = data_reg.byte_index;
    assign result.end_of_message = data_reg.end_of_message;

endmodule

@@ design/length_prefixed_deframer.sv @@
// Length-prefixed message deframer. One byte transfer is taken per cycle on stream; each
// message is an 8-byte header (type word, then payload length, both little-endian) followed
// by the payload. Every payload byte gives one result tagged with type, length and index,
// the last one marked end_of_message; an empty message gives one completion result and a
// length above max_payload_length (APB byte address 0, reset 4194304) gives a drop result.
// A byte passes an input register and then the result register, and the sustained rate
// is one byte per cycle, limited only by result.ready.
// Write the limit only while the block is idle.
module length_prefixed_deframer (
    input  logic                           clk,
    input  logic                           rst_n,
    lpd_byte_if.sink                       stream,
    lpd_result_if.source                   result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lpd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lpd_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic                 held_valid;
    logic [7:0]           held_byte;
    logic                 can_take;
    logic                 fire;
    logic [31:0]          max_len;
    logic                 res_valid;
    lpd_pkg::lpd_result_t res;

    assign fire = held_valid && can_take;

    lpd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .max_len (max_len)
    );

    lpd_input_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .advance    (fire),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    lpd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .in_byte   (held_byte),
        .max_len   (max_len),
        .res_valid (res_valid),
        .res       (res)
    );

    lpd_output_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .load      (res_valid),
        .load_data (res),
        .can_take  (can_take)
    );

`ifndef ASSERT_OFF
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.result_kind == lpd_pkg::KIND_PAYLOAD)
        |-> (result.byte_index < result.message_length))
        else $error("payload index not below message length");

    a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.result_kind == lpd_pkg::KIND_DROP)
        |-> (!result.end_of_message && (result.payload_byte == 8'd0)
             && (result.byte_index == 32'd0)))
        else $error("drop result carries payload fields");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.result_kind == lpd_pkg::KIND_EMPTY)
        |-> (result.end_of_message && (result.message_length == 32'd0)))
        else $error("empty completion malformed");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid && result.valid && !result.ready |-> !stream.ready)
        else $error("byte taken while pipeline stalled");
`endif

endmodule

@@ dv/length_prefixed_deframer_test.sv @@
// self-checking testbench for length_prefixed_deframer: byte stream in, result stream out
// depends on lpd_pkg, lpd_byte_if, lpd_result_if and the deframer rtl
// a scoreboard class predicts results per accepted byte; apb writes step through limits
module length_prefixed_deframer_test;

    localparam logic [lpd_pkg::APB_ADDR_W-1:0] ADDR_LIMIT = {lpd_pkg::REG_MAX_LEN, 2'b00};
    localparam logic [lpd_pkg::APB_ADDR_W-1:0] ADDR_SPARE = {~lpd_pkg::REG_MAX_LEN, 2'b00};
    localparam int DRAIN_CYCLES = 6;

    class deframer_scoreboard;
        lpd_pkg::lpd_result_t pending_results[$];
        logic [7:0]  hdr_bytes[lpd_pkg::HEADER_BYTES];
        logic [3:0]  hdr_cnt;
        logic [31:0] cur_type;
        logic [31:0] cur_len;
        logic [31:0] pay_cnt;
        logic [31:0] max_len;
        int unsigned bytes_seen;
        int          errors;

        function new();
            hdr_cnt = 0;
            cur_type = 0;
            cur_len = 0;
            pay_cnt = 0;
            max_len = lpd_pkg::MAX_LEN_RESET;
            bytes_seen = 0;
            errors = 0;
        endfunction

        function void set_limit(logic [31:0] v);
            max_len = v;
        endfunction

        function bit at_frame_start();
            return hdr_cnt == 0;
        endfunction

        function void report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endfunction

        function void push_result(lpd_pkg::lpd_kind_t kind, logic [7:0] data,
                                  logic [31:0] idx, logic last);
            lpd_pkg::lpd_result_t r;
            r.result_kind = kind;
            r.message_type = cur_type;
            r.message_length = cur_len;
            r.payload_byte = data;
            r.byte_index = idx;
            r.end_of_message = last;
            pending_results.push_back(r);
        endfunction

        function void close_frame();
            hdr_cnt = 0;
            cur_len = 0;
            pay_cnt = 0;
        endfunction

        function void deframe_byte(logic [7:0] b);
            logic last;
            bytes_seen++;
            if (hdr_cnt < lpd_pkg::HEADER_BYTES)
            begin
                hdr_bytes[hdr_cnt[2:0]] = b;
                hdr_cnt++;
                if (hdr_cnt < lpd_pkg::HEADER_BYTES)
                begin
                    return;
                end
                cur_type = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
                cur_len = {hdr_bytes[7], hdr_bytes[6], hdr_bytes[5], hdr_bytes[4]};
                if (cur_len > max_len)
                begin
                    push_result(lpd_pkg::KIND_DROP, 8'd0, 32'd0, 1'b0);
                    hdr_cnt = 0;
                    return;
                end
                pay_cnt = 0;
                if (cur_len == 0)
                begin
                    push_result(lpd_pkg::KIND_EMPTY, 8'd0, 32'd0, 1'b1);
                    close_frame();
                end
                return;
            end
            last = (pay_cnt + 32'd1 >= cur_len) || (pay_cnt == 32'hFFFF_FFFF);
            push_result(lpd_pkg::KIND_PAYLOAD, b, pay_cnt, last);
            if (last)
            begin
                close_frame();
            end
            else
            begin
                pay_cnt = pay_cnt + 32'd1;
            end
        endfunction

        function void compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
            begin
                report($sformatf("%s got %h expected %h", name, got, want));
            end
        endfunction

        function void check_result(lpd_pkg::lpd_result_t got);
            lpd_pkg::lpd_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d", got.result_kind));
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
            compare_field("message_type", got.message_type, want.message_type);
            compare_field("message_length", got.message_length, want.message_length);
            compare_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
            compare_field("byte_index", got.byte_index, want.byte_index);
            compare_field("end_of_message", 32'(got.end_of_message),
                          32'(want.end_of_message));
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [lpd_pkg::APB_ADDR_W-1:0] paddr;
    logic [lpd_pkg::APB_DATA_W-1:0] pwdata;
    logic [lpd_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    bit                             idle_en;

    deframer_scoreboard sb;

    lpd_byte_if   stream_if();
    lpd_result_if result_if();

    length_prefixed_deframer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #(8 * 400000);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int unsigned stall_left;
        lpd_pkg::lpd_result_t got;
        stall_left = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_if.valid && result_if.ready)
            begin
                got.result_kind = lpd_pkg::lpd_kind_t'(result_if.result_kind);
                got.message_type = result_if.message_type;
                got.message_length = result_if.message_length;
                got.payload_byte = result_if.payload_byte;
                got.byte_index = result_if.byte_index;
                got.end_of_message = result_if.end_of_message;
                sb.check_result(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            stream_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        stream_if.valid <= 1'b1;
        stream_if.in_byte <= b;
        do
            @(posedge clk);
        while (!stream_if.ready);
        sb.deframe_byte(b);
    endtask

    task automatic push_message(logic [31:0] typ, logic [31:0] len, int unsigned hdr_n,
                                int unsigned pay_n);
        for (int i = 0; i < hdr_n; i++)
        begin
            send_byte((i < 4) ? typ[8*i +: 8] : len[8*(i-4) +: 8]);
        end
        repeat (pay_n) send_byte(8'($urandom));
    endtask

    task automatic wait_drained();
        stream_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(logic [lpd_pkg::APB_ADDR_W-1:0] addr, logic wr,
                              logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_limit(logic [31:0] v, bit to_spare);
        logic [31:0] rd;
        if (to_spare)
        begin
            apb_access(ADDR_SPARE, 1'b1, v, rd);
        end
        else
        begin
            apb_access(ADDR_LIMIT, 1'b1, v, rd);
            sb.set_limit(v);
        end
        apb_access(ADDR_LIMIT, 1'b0, 32'd0, rd);
        if (rd !== sb.max_len)
        begin
            sb.report($sformatf("limit readback %h expected %h", rd, sb.max_len));
        end
    endtask

    function automatic logic [31:0] pick_type();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 32'd0;
        end
        if (r == 1)
        begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_length(logic [31:0] lim);
        int unsigned r;
        logic [31:0] cap;
        r = $urandom_range(0, 99);
        cap = (lim < 24) ? lim : 32'd24;
        if (r < 12)
        begin
            return 32'd0;
        end
        if (r < 24 && lim != 32'hFFFF_FFFF)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                return lim + 32'd1;
            end
            if ($urandom_range(0, 1) == 0)
            begin
                return 32'hFFFF_FFFF;
            end
            return lim + 32'd1 + ($urandom % (32'hFFFF_FFFF - lim));
        end
        if (r < 30 && lim <= 64)
        begin
            return lim;
        end
        if (cap == 0)
        begin
            return 32'd0;
        end
        return $urandom_range(1, cap);
    endfunction

    // rough phases mix in noise and cut-short frames; only used with small limits
    task automatic run_phase(int unsigned upto, bit rough);
        int unsigned r;
        logic [31:0] len;
        while (sb.bytes_seen < upto)
        begin
            while (!sb.at_frame_start())
            begin
                send_byte(8'($urandom));
            end
            r = $urandom_range(0, 99);
            len = pick_length(sb.max_len);
            if (rough && r < 10)
            begin
                repeat (8) send_byte(8'($urandom));
            end
            else if (rough && r < 15)
            begin
                push_message(pick_type(), len, $urandom_range(1, 7), 0);
            end
            else if (rough && r < 20)
            begin
                push_message(pick_type(), len, 8,
                             (len > 1 && len <= sb.max_len) ? $urandom_range(1, len - 1) : 0);
            end
            else
            begin
                push_message(pick_type(), len, 8, (len <= sb.max_len) ? len : 0);
            end
            if ($urandom_range(0, 49) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    initial
    begin
        sb = new();
        idle_en = 1'b1;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        stream_if.valid = 1'b0;
        stream_if.in_byte = 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, single byte message, oversized header at reset limit
        push_message(32'hFFFF_FFFF, 32'd0, 8, 0);
        push_message(32'd0, 32'd1, 8, 0);
        send_byte(8'hFF);
        push_message(32'hA5C3_0F96, lpd_pkg::MAX_LEN_RESET + 32'd1, 8, 0);
        run_phase(250, 1'b0);
        wait_drained();

        program_limit($urandom, 1'b1);
        program_limit(32'd0, 1'b0);
        run_phase(400, 1'b1);
        wait_drained();

        program_limit(32'hFFFF_FFFF, 1'b0);
        run_phase(600, 1'b0);
        wait_drained();

        program_limit($urandom_range(1, 48), 1'b0);
        run_phase(850, 1'b1);
        wait_drained();

        program_limit($urandom_range(1, 4), 1'b0);
        run_phase(1000, 1'b1);
        wait_drained();

        // back-to-back transfers on both sides to the end
        idle_en = 1'b0;
        program_limit(32'd16, 1'b0);
        run_phase(1300, 1'b1);
        while (!sb.at_frame_start())
        begin
            send_byte(8'($urandom));
        end
        wait_drained();

        if (sb.errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
